>>> rtl/gds_pkg.sv
// Shared types and constants for the Gregorian date stepper.
// No dependencies; imported by every module of the block.
package gds_pkg;

   // field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DOY_W   = 9;

   // leap test: year / 25 by reciprocal multiply, exact for all 14-bit years
   localparam int RECIP_W     = 15;
   localparam int LEAP_RECIP  = 20972;   // ceil(2^19 / 25)
   localparam int LEAP_SHIFT  = 19;
   localparam int LEAP_PROD_W = YEAR_W + RECIP_W;
   localparam int QUOT_W      = 10;      // 16383 / 25 < 1024

   // request command codes
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_SUB   = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_EXEC,
      ST_STEP,
      ST_SETTLE1,
      ST_SETTLE2,
      ST_CAPTURE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture_req;   // register the request word
      logic use_req_year;  // leap unit looks at the requested year
      logic commit_load;   // check and commit a load
      logic step;          // move the date by one day
      logic set_limit;     // flag saturation
      logic capture_rsp;   // register the response word
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;        // command of the word in progress
      logic    cnt_zero;   // no days left to step
      logic    at_limit;   // date sits at the limit in the step direction
   } dp_status_type;

endpackage

>>> rtl/gregorian_date_stepper.sv
// A word passes ST_PREP1 and ST_PREP2, then ST_EXEC for a load or the step loop for an
// add/subtract (one day per cycle until the count is spent or the limit is reached),
// then ST_SETTLE1, ST_SETTLE2 (two-stage leap unit) and ST_CAPTURE, held by rsp_stall.
// A new word is taken the cycle after its predecessor's response is registered.
// Reset: date 1-01-01, no response pending, controller idle.
// Top level of the date stepper; depends on gds_pkg, gds_ctrl, gds_dpath.
module gregorian_date_stepper import gds_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int MAX_YEAR   = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [DAY_W-1:0]   req_in_day,
   input  logic [MONTH_W-1:0] req_in_month,
   input  logic [YEAR_W-1:0]  req_in_year,
   input  logic [15:0]        req_day_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DAY_W-1:0]   rsp_out_day,
   output logic [MONTH_W-1:0] rsp_out_month,
   output logic [YEAR_W-1:0]  rsp_out_year,
   output logic               rsp_leap_year,
   output logic [DOY_W-1:0]   rsp_day_of_year,
   output logic               rsp_load_valid,
   output logic               rsp_limit_hit
);

   ctl_cmd_type   ctl;
   dp_status_type status;

   gds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctl       (ctl)
   );

   gds_dpath #(
      .COUNT_BITS (COUNT_BITS),
      .MAX_YEAR   (MAX_YEAR)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_in_day      (req_in_day),
      .req_in_month    (req_in_month),
      .req_in_year     (req_in_year),
      .req_day_count   (req_day_count),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_leap_year   (rsp_leap_year),
      .rsp_day_of_year (rsp_day_of_year),
      .rsp_load_valid  (rsp_load_valid),
      .rsp_limit_hit   (rsp_limit_hit)
   );

endmodule

>>> rtl/gds_leap.sv
// Two-stage Gregorian leap-year unit (4/100/400 rule).
// Depends on gds_pkg; the year is registered with its quotient, then the leap flag is registered.
module gds_leap import gds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [YEAR_W-1:0] year,
   output logic              leap
);

   logic [LEAP_PROD_W-1:0] prod;
   logic [QUOT_W-1:0]      quot_ff;
   logic [QUOT_W-1:0]      quot_in;
   logic [YEAR_W-1:0]      yr_ff;
   logic [YEAR_W-1:0]      q25;
   logic                   rem_zero;
   logic                   leap_ff;
   logic                   leap_in;

   // stage 1: quotient by 25
   assign prod    = LEAP_PROD_W'(year) * LEAP_PROD_W'(LEAP_RECIP);
   assign quot_in = prod[LEAP_SHIFT +: QUOT_W];

   // stage 2: remainder test; 400 = 16 * 25
   assign q25      = YEAR_W'({quot_ff, 4'b0000}) + YEAR_W'({quot_ff, 3'b000})
                   + YEAR_W'(quot_ff);
   assign rem_zero = (yr_ff == q25);
   assign leap_in  = ((yr_ff[1:0] == 2'b00) && !rem_zero) ||
                     ((yr_ff[3:0] == 4'b0000) && rem_zero);

   // reset values match year 1
   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff <= '0;
         yr_ff   <= YEAR_W'(1);
         leap_ff <= 1'b0;
      end else begin
         quot_ff <= quot_in;
         yr_ff   <= year;
         leap_ff <= leap_in;
      end
   end

   assign leap = leap_ff;

endmodule

>>> rtl/gds_ctrl.sv
// Controller state machine of the date stepper.
// Depends on gds_pkg; drives the handshakes and the datapath commands.
module gds_ctrl import gds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctl_cmd_type   ctl
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;
   logic      step_done;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step_done = status.cnt_zero || status.at_limit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_PREP1;
         ST_PREP1:    state_in = ST_PREP2;
         ST_PREP2: begin
            case (status.cmd)
               CMD_LOAD:         state_in = ST_EXEC;
               CMD_ADD, CMD_SUB: state_in = ST_STEP;
               default:          state_in = ST_SETTLE1;
            endcase
         end
         ST_EXEC:     state_in = ST_SETTLE1;
         ST_STEP:     if (step_done) state_in = ST_SETTLE1;
         ST_SETTLE1:  state_in = ST_SETTLE2;
         ST_SETTLE2:  state_in = ST_CAPTURE;
         ST_CAPTURE:  if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs; only a load looks at the requested year, steps need the stored one
   always_comb begin
      ctl              = '0;
      req_stall        = (state_ff != ST_IDLE);
      ctl.capture_req  = (state_ff == ST_IDLE) && req_valid;
      ctl.use_req_year = (state_ff == ST_PREP1) && (status.cmd == CMD_LOAD);
      ctl.commit_load  = (state_ff == ST_EXEC);
      ctl.step         = (state_ff == ST_STEP) && !step_done;
      ctl.set_limit    = (state_ff == ST_STEP) && !status.cnt_zero && status.at_limit;
      ctl.capture_rsp  = (state_ff == ST_CAPTURE) && rsp_free;
   end

   // response valid: set on capture, cleared when the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (ctl.capture_rsp)            rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/gds_dpath.sv
// Datapath of the date stepper: stored date, day counter, flags, output word.
// Depends on gds_pkg and gds_leap; commanded by gds_ctrl.
module gds_dpath import gds_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int MAX_YEAR   = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        ctl,
   output dp_status_type      status,
   input  logic [1:0]         req_cmd,
   input  logic [DAY_W-1:0]   req_in_day,
   input  logic [MONTH_W-1:0] req_in_month,
   input  logic [YEAR_W-1:0]  req_in_year,
   input  logic [15:0]        req_day_count,
   output logic [DAY_W-1:0]   rsp_out_day,
   output logic [MONTH_W-1:0] rsp_out_month,
   output logic [YEAR_W-1:0]  rsp_out_year,
   output logic               rsp_leap_year,
   output logic [DOY_W-1:0]   rsp_day_of_year,
   output logic               rsp_load_valid,
   output logic               rsp_limit_hit
);

   localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);

   // days in a month; zero for a month code that means nothing
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

   // days before the first of a month in a common year
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      case (m)
         4'd2:    d = DOY_W'(31);
         4'd3:    d = DOY_W'(59);
         4'd4:    d = DOY_W'(90);
         4'd5:    d = DOY_W'(120);
         4'd6:    d = DOY_W'(151);
         4'd7:    d = DOY_W'(181);
         4'd8:    d = DOY_W'(212);
         4'd9:    d = DOY_W'(243);
         4'd10:   d = DOY_W'(273);
         4'd11:   d = DOY_W'(304);
         4'd12:   d = DOY_W'(334);
         default: d = '0;
      endcase
      return d;
   endfunction

   // request word
   cmd_type               cmd_ff;
   logic [DAY_W-1:0]      ld_day_ff;
   logic [MONTH_W-1:0]    ld_month_ff;
   logic [YEAR_W-1:0]     ld_year_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [COUNT_BITS-1:0] cnt_in;

   // stored date
   logic [DAY_W-1:0]      day_ff,   day_in;
   logic [MONTH_W-1:0]    month_ff, month_in;
   logic [YEAR_W-1:0]     year_ff,  year_in;

   // status flags of the word in progress
   logic                  valid_ff, valid_in;
   logic                  limit_ff, limit_in;

   // response word
   logic [DAY_W-1:0]      out_day_ff;
   logic [MONTH_W-1:0]    out_month_ff;
   logic [YEAR_W-1:0]     out_year_ff;
   logic                  out_leap_ff;
   logic [DOY_W-1:0]      out_doy_ff;
   logic                  out_valid_ff;
   logic                  out_limit_ff;

   logic [YEAR_W-1:0]     leap_year_sel;
   logic                  leap;
   logic [DAY_W-1:0]      cur_len;
   logic [DAY_W-1:0]      prev_len;
   logic [MONTH_W-1:0]    prev_month;
   logic                  load_ok;
   logic [DOY_W-1:0]      doy;

   // leap flag of the requested year while a load is checked, else of the stored year
   assign leap_year_sel = ctl.use_req_year ? ld_year_ff : year_ff;

   gds_leap u_leap (
      .clock (clock),
      .reset (reset),
      .year  (leap_year_sel),
      .leap  (leap)
   );

   assign cur_len    = month_len(month_ff, leap);
   assign prev_month = month_ff - MONTH_W'(1);
   assign prev_len   = month_len(prev_month, leap);

   // load check; leap here belongs to the requested year
   assign load_ok = (ld_year_ff != '0) && (ld_year_ff <= MAX_YEAR_V) &&
                    (ld_day_ff != '0) && (ld_day_ff <= month_len(ld_month_ff, leap));

   // status
   always_comb begin
      status.cmd      = cmd_ff;
      status.cnt_zero = (cnt_ff == '0);
      if (cmd_ff == CMD_ADD) begin
         status.at_limit = (year_ff >= MAX_YEAR_V) && (month_ff == MONTH_W'(12)) &&
                           (day_ff == DAY_W'(31));
      end else begin
         status.at_limit = (year_ff <= YEAR_W'(1)) && (month_ff == MONTH_W'(1)) &&
                           (day_ff == DAY_W'(1));
      end
   end

   // date update: load commit or one day forward / back
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      if (ctl.commit_load && load_ok) begin
         day_in   = ld_day_ff;
         month_in = ld_month_ff;
         year_in  = ld_year_ff;
      end else if (ctl.step && (cmd_ff == CMD_ADD)) begin
         if (day_ff < cur_len) begin
            day_in = day_ff + DAY_W'(1);
         end else if (month_ff < MONTH_W'(12)) begin
            month_in = month_ff + MONTH_W'(1);
            day_in   = DAY_W'(1);
         end else begin
            year_in  = year_ff + YEAR_W'(1);
            month_in = MONTH_W'(1);
            day_in   = DAY_W'(1);
         end
      end else if (ctl.step) begin
         if (day_ff > DAY_W'(1)) begin
            day_in = day_ff - DAY_W'(1);
         end else if (month_ff > MONTH_W'(1)) begin
            month_in = prev_month;
            day_in   = prev_len;
         end else begin
            year_in  = year_ff - YEAR_W'(1);
            month_in = MONTH_W'(12);
            day_in   = DAY_W'(31);
         end
      end
   end

   // day counter and flags
   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      limit_in = limit_ff;
      if (ctl.capture_req) begin
         cnt_in   = COUNT_BITS'(32'(req_day_count));
         valid_in = 1'b1;
         limit_in = 1'b0;
      end else begin
         if (ctl.step)                      cnt_in   = cnt_ff - COUNT_BITS'(1);
         if (ctl.commit_load && !load_ok)   valid_in = 1'b0;
         if (ctl.set_limit)                 limit_in = 1'b1;
      end
   end

   // ordinal day; month is always 1..12 here
   assign doy = days_before(month_ff) + DOY_W'(day_ff) +
                DOY_W'(leap && (month_ff > MONTH_W'(2)));

   // stored date and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= DAY_W'(1);
         month_ff <= MONTH_W'(1);
         year_ff  <= YEAR_W'(1);
         valid_ff <= 1'b1;
         limit_ff <= 1'b0;
         cnt_ff   <= '0;
         cmd_ff   <= CMD_QUERY;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         valid_ff <= valid_in;
         limit_ff <= limit_in;
         cnt_ff   <= cnt_in;
         if (ctl.capture_req) cmd_ff <= cmd_type'(req_cmd);
      end
   end

   // request and response words
   always_ff @(posedge clock) begin
      if (ctl.capture_req) begin
         ld_day_ff   <= req_in_day;
         ld_month_ff <= req_in_month;
         ld_year_ff  <= req_in_year;
      end
      if (ctl.capture_rsp) begin
         out_day_ff   <= day_ff;
         out_month_ff <= month_ff;
         out_year_ff  <= year_ff;
         out_leap_ff  <= leap;
         out_doy_ff   <= doy;
         out_valid_ff <= valid_ff;
         out_limit_ff <= limit_ff;
      end
   end

   assign rsp_out_day     = out_day_ff;
   assign rsp_out_month   = out_month_ff;
   assign rsp_out_year    = out_year_ff;
   assign rsp_leap_year   = out_leap_ff;
   assign rsp_day_of_year = out_doy_ff;
   assign rsp_load_valid  = out_valid_ff;
   assign rsp_limit_hit   = out_limit_ff;

endmodule
